[src/directional_thinning_pass_macros.svh]
// Assertion macros shared by the directional thinning pass checkers.
`ifndef DIRECTIONAL_THINNING_PASS_MACROS_SVH
`define DIRECTIONAL_THINNING_PASS_MACROS_SVH

// Same-cycle implication, sampled on clk and muted while rst is high.
`define DTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and muted while rst is high.
`define DTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/dtp_pkg.sv]
// Package with shared types, codes and the per-pixel thinning test.
`default_nettype none

package dtp_pkg;

  // Configuration register indexes.
  localparam logic REG_DIRECTION    = 1'b0;
  localparam logic REG_ACTIVE_WIDTH = 1'b1;

  // Register reset values.
  localparam logic [1:0] DIRECTION_RESET = 2'd0;
  localparam logic [6:0] WIDTH_RESET     = 7'd64;

  // Result queue geometry.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Thinning side.
  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_EAST  = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  // Bits one column cell shows to its neighbors.
  typedef struct packed {
    logic older;
    logic center;
    logic fresh;
  } dtp_col_t;

  // Per-column results of both windows a cell evaluates.
  typedef struct packed {
    logic kept_a;
    logic kept_b;
    logic drop_a;
    logic drop_b;
  } dtp_res_t;

  // Decide whether the center pixel of a 3x3 window is cleared.
  // p_* is the row above, c_* the center row, n_* the row below.
  function automatic logic thin_drop(
    input logic [1:0] dir,
    input logic ctr,
    input logic p_l, input logic p_c, input logic p_r,
    input logic c_l, input logic c_r,
    input logic n_l, input logic n_c, input logic n_r
  );
    logic [3:0] chi;
    logic [3:0] sigma;
    logic       clr;
    logic       set;
    // Edge changes around the 4-neighbors plus doubled corner terms.
    chi = 4'(n_c ^ c_r) + 4'(c_r ^ p_c) + 4'(p_c ^ c_l) + 4'(c_l ^ n_c)
        + {2'b00, (n_r & ~n_c & ~c_r), 1'b0}
        + {2'b00, (p_r & ~c_r & ~p_c), 1'b0}
        + {2'b00, (p_l & ~p_c & ~c_l), 1'b0}
        + {2'b00, (n_l & ~c_l & ~n_c), 1'b0};
    sigma = 4'(n_c) + 4'(n_r) + 4'(c_r) + 4'(p_r)
          + 4'(p_c) + 4'(p_l) + 4'(c_l) + 4'(n_l);
    case (dir_t'(dir))
      DIR_NORTH: begin clr = n_c; set = p_c; end
      DIR_SOUTH: begin clr = p_c; set = n_c; end
      DIR_EAST:  begin clr = c_r; set = c_l; end
      DIR_WEST:  begin clr = c_l; set = c_r; end
      default:   begin clr = 1'b1; set = 1'b0; end
    endcase
    return ctr && (chi == 4'd2) && (sigma != 4'd1) && !clr && set;
  endfunction

endpackage

`default_nettype wire

[src/dtp_cell.sv]
// One column cell: holds two past pixels and tests both thinning windows.
`default_nettype none

module dtp_cell #(
  parameter int COL = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              final_row,
  input  wire logic              pixel_in,
  input  wire logic [6:0]        active_width,
  input  wire logic [1:0]        direction,
  input  wire dtp_pkg::dtp_col_t left,
  input  wire dtp_pkg::dtp_col_t right,
  output dtp_pkg::dtp_col_t      here,
  output dtp_pkg::dtp_res_t      res
);

  logic older;
  logic center;
  logic fresh;

  // Columns at or beyond the active width read clear.
  assign fresh = pixel_in & (7'(COL) < active_width);

  assign here.older  = older;
  assign here.center = center;
  assign here.fresh  = fresh;

  // Window A thins the held center row; window B thins the incoming row
  // as the last row of the frame, with a clear row below it.
  always_comb begin
    res.drop_a = dtp_pkg::thin_drop(direction, center,
                                    left.older, older, right.older,
                                    left.center, right.center,
                                    left.fresh, fresh, right.fresh);
    res.drop_b = dtp_pkg::thin_drop(direction, fresh,
                                    left.center, center, right.center,
                                    left.fresh, right.fresh,
                                    1'b0, 1'b0, 1'b0);
    res.kept_a = center & ~res.drop_a;
    res.kept_b = fresh & ~res.drop_b;
  end

  // Shift the column history down by one row, or clear it at frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      older  <= 1'b0;
      center <= 1'b0;
    end else if (accept) begin
      if (final_row) begin
        older  <= 1'b0;
        center <= 1'b0;
      end else begin
        older  <= center;
        center <= fresh;
      end
    end
  end

endmodule

`default_nettype wire

[src/dtp_out_fifo.sv]
// Small result queue taking up to two beats per cycle and giving one unless its head is stalled.
`default_nettype none

module dtp_out_fifo #(
  parameter int WIDTH = 66
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_a,
  input  wire logic [WIDTH-1:0] data_a,
  input  wire logic             push_b,
  input  wire logic [WIDTH-1:0] data_b,
  output logic                  room,
  output logic                  head_valid,
  input  wire logic             head_stall,
  output logic [WIDTH-1:0]      head_data
);

  logic [WIDTH-1:0]              mem [dtp_pkg::OUT_DEPTH];
  logic [dtp_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [dtp_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [dtp_pkg::OUT_CNT_W-1:0] count;
  logic [dtp_pkg::OUT_PTR_W-1:0] wr_ptr_b;
  logic                          pop;

  // Space for two beats is needed before a new row may enter.
  assign room       = count <= dtp_pkg::OUT_CNT_W'(dtp_pkg::OUT_DEPTH - 2);
  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];
  assign pop        = head_valid & ~head_stall;
  assign wr_ptr_b   = wr_ptr + dtp_pkg::OUT_PTR_W'(push_a);

  // Storage writes; the second beat lands behind the first.
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr_b] <= data_b;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dtp_pkg::OUT_PTR_W'(push_a) + dtp_pkg::OUT_PTR_W'(push_b);
      rd_ptr <= rd_ptr + dtp_pkg::OUT_PTR_W'(pop);
      count  <= count + dtp_pkg::OUT_CNT_W'(push_a) + dtp_pkg::OUT_CNT_W'(push_b)
              - dtp_pkg::OUT_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

[src/directional_thinning_pass.sv]
// Directional thinning pass: one input row per cycle while in_stall is low; a row's
// result is queued when the next row is accepted, and a final row adds its own result too.
// Throughput is one row per cycle unless the full result queue stalls the input; a final
// row adds a second result beat, and the queue hands out one beat per cycle unless stalled.
// Synchronous reset clears the row history, the queue and the registers
// (direction north, active width 64).
`default_nettype none

module directional_thinning_pass #(
  parameter int ROW_WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [6:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ROW_WIDTH-1:0] row_pixels,
  input  wire logic                 final_row,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ROW_WIDTH-1:0]      thinned_row,
  output logic                      frame_done,
  output logic                      any_removed
);

  localparam int ENTRY_W = ROW_WIDTH + 2;

  logic [1:0]              direction;
  logic [6:0]              active_width;
  logic                    held;
  logic                    removed_seen;
  logic                    accept;
  logic                    room;
  dtp_pkg::dtp_col_t       col [ROW_WIDTH];
  logic [ROW_WIDTH-1:0]    kept_a;
  logic [ROW_WIDTH-1:0]    kept_b;
  logic [ROW_WIDTH-1:0]    drop_a;
  logic [ROW_WIDTH-1:0]    drop_b;
  logic                    removed_a;
  logic [ENTRY_W-1:0]      entry_a;
  logic [ENTRY_W-1:0]      entry_b;
  logic [ENTRY_W-1:0]      head;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = ~room;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= dtp_pkg::DIRECTION_RESET;
      active_width <= dtp_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dtp_pkg::REG_DIRECTION:    direction    <= cfg_data[1:0];
        dtp_pkg::REG_ACTIVE_WIDTH: active_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row of column cells; each sees its two neighbors, the edges read clear.
  for (genvar x = 0; x < ROW_WIDTH; x++) begin : g_col
    dtp_pkg::dtp_col_t left;
    dtp_pkg::dtp_col_t right;
    dtp_pkg::dtp_res_t res;

    if (x == 0) begin : g_left_edge
      assign left = '0;
    end else begin : g_left
      assign left = col[x-1];
    end
    if (x == ROW_WIDTH - 1) begin : g_right_edge
      assign right = '0;
    end else begin : g_right
      assign right = col[x+1];
    end

    dtp_cell #(.COL(x)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .accept       (accept),
      .final_row    (final_row),
      .pixel_in     (row_pixels[x]),
      .active_width (active_width),
      .direction    (direction),
      .left         (left),
      .right        (right),
      .here         (col[x]),
      .res          (res)
    );

    assign kept_a[x] = res.kept_a;
    assign kept_b[x] = res.kept_b;
    assign drop_a[x] = res.drop_a;
    assign drop_b[x] = res.drop_b;
  end

  // Result beats: the held row, and on the final row the final row itself.
  assign removed_a = held & (|drop_a);
  assign entry_a   = {kept_a, 1'b0, 1'b0};
  assign entry_b   = {kept_b, 1'b1, removed_seen | removed_a | (|drop_b)};

  // Frame bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      removed_seen <= 1'b0;
    end else if (accept) begin
      if (final_row) begin
        held         <= 1'b0;
        removed_seen <= 1'b0;
      end else begin
        held         <= 1'b1;
        removed_seen <= removed_seen | removed_a;
      end
    end
  end

  dtp_out_fifo #(.WIDTH(ENTRY_W)) u_out (
    .clk        (clk),
    .rst        (rst),
    .push_a     (accept & held),
    .data_a     (entry_a),
    .push_b     (accept & final_row),
    .data_b     (entry_b),
    .room       (room),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head_data  (head)
  );

  assign thinned_row = head[ENTRY_W-1:2];
  assign frame_done  = head[1];
  assign any_removed = head[0];

endmodule

`default_nettype wire

[src/dtp_checker.sv]
// Port-level checker for the directional thinning pass, bound to the top level.
`default_nettype none
`include "directional_thinning_pass_macros.svh"

module dtp_checker #(
  parameter int ROW_WIDTH = 64
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 final_row,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [ROW_WIDTH-1:0] thinned_row,
  input wire logic                 frame_done,
  input wire logic                 any_removed
);

  // A stalled result beat stays put.
  `DTP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(thinned_row) && $stable(frame_done) && $stable(any_removed), "stalled result beat changed")

  // The removal flag only rides on the last beat of a frame.
  `DTP_ASSERT_NOW(a_flag_on_last, out_valid && !frame_done, !any_removed, "any_removed set on a non-final beat")

  // A final row always yields a result beat.
  `DTP_ASSERT_NEXT(a_final_emits, in_valid && !in_stall && final_row, out_valid, "final row produced no result")

  // With nothing queued the input side is never held off.
  `DTP_ASSERT_NOW(a_empty_ready, !out_valid, !in_stall, "input stalled with empty result queue")

endmodule

bind directional_thinning_pass dtp_checker #(.ROW_WIDTH(ROW_WIDTH)) u_dtp_checker (.*);

`default_nettype wire
